// ----- src/bsp_pkg.sv -----
package bsp_pkg;

   // Capacity of the store; a set longer than this is cut and flagged.
   localparam int MAX_ITEMS = 64;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   // Padding can reach the next power of two, so the store is that deep.
   localparam int DEPTH     = 1 << ADDR_W;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int PW        = ADDR_W + 1;
   localparam int LG_W      = $clog2(ADDR_W + 1);

   localparam logic [63:0] SENTINEL_KEY = '1;

   typedef struct packed {
      logic [63:0] item_key;
      logic [63:0] item_payload;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] out_key;
      logic [63:0] out_payload;
      logic        out_last;
      logic        overflowed;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] payload;
   } entry_type;

   // Current compare-swap pair of the sorting network.
   typedef struct packed {
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic              up;
      logic              last;
   } pair_type;

   // Smallest exponent whose power of two covers n items.
   function automatic logic [LG_W-1:0] ceil_lg(input logic [CNT_W-1:0] n);
      logic [LG_W-1:0] r;
      r = LG_W'(ADDR_W);
      for (int b = ADDR_W; b >= 0; b--) begin
         if ((PW'(1) << b) >= PW'(n)) begin
            r = LG_W'(b);
         end
      end
      return r;
   endfunction

endpackage

// ----- src/bsp_ram.sv -----
module bsp_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ----- src/bsp_seq.sv -----
module bsp_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     advance,
   input  logic [bsp_pkg::LG_W-1:0] lgp,
   output bsp_pkg::pair_type        pair
);
   import bsp_pkg::*;

   // ks: log of the bitonic block size, js: log of the compare distance,
   // q: index of the pair within the current layer.
   logic [LG_W-1:0]   ks_ff, ks_in;
   logic [LG_W-1:0]   js_ff, js_in;
   logic [ADDR_W-1:0] q_ff, q_in;
   logic [PW-1:0]     half_p, q_w, lo_w, hi_w;
   logic              q_last;

   always_comb begin
      half_p = (PW'(1) << lgp) >> 1;
      q_w    = PW'(q_ff);
      q_last = (q_w == half_p - PW'(1));
      // Insert a zero at bit js to get the lower index of the pair.
      lo_w   = ((q_w >> js_ff) << (js_ff + LG_W'(1)))
             | (q_w & ((PW'(1) << js_ff) - PW'(1)));
      hi_w   = lo_w | (PW'(1) << js_ff);

      pair.lo   = lo_w[ADDR_W-1:0];
      pair.hi   = hi_w[ADDR_W-1:0];
      pair.up   = (((lo_w >> ks_ff) & PW'(1)) == '0);
      pair.last = q_last && (js_ff == '0) && (ks_ff == lgp);

      ks_in = ks_ff;
      js_in = js_ff;
      q_in  = q_ff;
      if (start) begin
         ks_in = LG_W'(1);
         js_in = '0;
         q_in  = '0;
      end else if (advance) begin
         if (!q_last) begin
            q_in = q_ff + ADDR_W'(1);
         end else begin
            q_in = '0;
            if (js_ff != '0) begin
               js_in = js_ff - LG_W'(1);
            end else begin
               ks_in = ks_ff + LG_W'(1);
               js_in = ks_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ff <= LG_W'(1);
         js_ff <= '0;
         q_ff  <= '0;
      end else begin
         ks_ff <= ks_in;
         js_ff <= js_in;
         q_ff  <= q_in;
      end
   end

endmodule

// ----- src/bitonic_sort_padded.sv -----
// Operation: input transactions are loaded while no sort runs; after the last one come a setup
// step, sentinel writes up to the padded size, a read and a compare for each compare-swap, a
// second write when a pair swaps, then the read-out of the results, held while the output stalls.
// Throughput: one set at a time; the shared compare unit and the single memory write port set it.
// Reset: synchronous, active high; it clears the count, the overflow flag, the sequencer and
// the output valid. The item store is not cleared; only entries written for the set are read.
module bitonic_sort_padded (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bsp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsp_pkg::rsp_type rsp_data
);
   import bsp_pkg::*;

   // Controller states.
   localparam logic [2:0] ST_LOAD = 3'd0;  // taking input transactions
   localparam logic [2:0] ST_PREP = 3'd1;  // work out the padded size
   localparam logic [2:0] ST_PAD  = 3'd2;  // write sentinels up to the padded size
   localparam logic [2:0] ST_READ = 3'd3;  // read both entries of the current pair
   localparam logic [2:0] ST_CMP  = 3'd4;  // compare; write the low entry on a swap
   localparam logic [2:0] ST_WRB  = 3'd5;  // write the high entry of a swap
   localparam logic [2:0] ST_EMIT = 3'd6;  // read out the sorted prefix

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [LG_W-1:0]   lgp_ff, lgp_in;
   logic [PW-1:0]     pad_ff, pad_in;
   logic [CNT_W-1:0]  emit_ff, emit_in;
   logic              inflight_ff, inflight_in;
   entry_type         hold_ff, hold_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Memory port signals.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
   entry_type         rd_a, rd_b;

   // Sequencer handshake.
   logic              seq_start, seq_adv;
   pair_type          pair;

   logic              swap;
   logic              rsp_take;

   // Key and payload live side by side in one entry of the store; the sort
   // works in place, so the store is also the working array of the network.
   bsp_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH),
      .AW    (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // The sequencer walks the bitonic network layer by layer. Pairs within a
   // layer touch disjoint entries, and every pair finishes its writes before
   // the next read is issued, so no forwarding is needed.
   bsp_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (seq_start),
      .advance (seq_adv),
      .lgp     (lgp_ff),
      .pair    (pair)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      lgp_in       = lgp_ff;
      pad_in       = pad_ff;
      emit_in      = emit_ff;
      inflight_in  = inflight_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      wr_en             = 1'b0;
      wr_addr           = count_ff[ADDR_W-1:0];
      wr_data.key       = req_data.item_key;
      wr_data.payload   = req_data.item_payload;
      rd_addr_a         = pair.lo;
      rd_addr_b         = pair.hi;
      seq_start         = 1'b0;
      seq_adv           = 1'b0;

      req_stall = (state_ff != ST_LOAD);

      // An ascending pair swaps only when the high key is strictly smaller;
      // a descending pair swaps otherwise, so equal keys do swap there.
      swap = pair.up ? (rd_b.key < rd_a.key) : !(rd_b.key < rd_a.key);

      rsp_take = rsp_valid_ff && !rsp_stall;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  // The store is full: the transaction is dropped and flagged.
                  ovf_in = 1'b1;
               end
               if (req_data.is_last) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            lgp_in    = ceil_lg(count_ff);
            pad_in    = PW'(count_ff);
            emit_in   = '0;
            seq_start = 1'b1;
            state_in  = ST_PAD;
         end
         ST_PAD: begin
            if (pad_ff < (PW'(1) << lgp_ff)) begin
               wr_en           = 1'b1;
               wr_addr         = pad_ff[ADDR_W-1:0];
               wr_data.key     = SENTINEL_KEY;
               wr_data.payload = '0;
               pad_in          = pad_ff + PW'(1);
            end else if (lgp_ff != '0) begin
               state_in = ST_READ;
            end else begin
               // A single item needs no sorting.
               state_in = ST_EMIT;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (swap) begin
               wr_en    = 1'b1;
               wr_addr  = pair.lo;
               wr_data  = rd_b;
               hold_in  = rd_a;
               state_in = ST_WRB;
            end else if (pair.last) begin
               state_in = ST_EMIT;
            end else begin
               seq_adv  = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_WRB: begin
            wr_en   = 1'b1;
            wr_addr = pair.hi;
            wr_data = hold_ff;
            if (pair.last) begin
               state_in = ST_EMIT;
            end else begin
               seq_adv  = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            rd_addr_a = emit_ff[ADDR_W-1:0];
            if (inflight_ff) begin
               // The output register is free here: a read is only issued
               // when it is empty or being taken in that cycle.
               rsp_in.out_key     = rd_a.key;
               rsp_in.out_payload = rd_a.payload;
               rsp_in.out_last    = (emit_ff == count_ff);
               rsp_in.overflowed  = ovf_ff;
               rsp_valid_in       = 1'b1;
               inflight_in        = 1'b0;
               if (emit_ff == count_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end else if ((emit_ff < count_ff) && (!rsp_valid_ff || !rsp_stall)) begin
               emit_in     = emit_ff + CNT_W'(1);
               inflight_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         lgp_ff       <= '0;
         pad_ff       <= '0;
         emit_ff      <= '0;
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         lgp_ff       <= lgp_in;
         pad_ff       <= pad_in;
         emit_ff      <= emit_in;
         inflight_ff  <= inflight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/bsp_checker.sv -----
module bsp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input bsp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bsp_pkg::rsp_type rsp_data
);
   import bsp_pkg::*;

   // A stalled result transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result valid dropped while stalled");

   // A stalled result transaction keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // Closing a set starts the sort, so input is held off on the next cycle.
   a_sort_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.is_last |=> req_stall)
      else $error("input taken right after the last item of a set");

   // While a run is still being emitted, no new input is taken.
   a_no_load_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_last |-> req_stall)
      else $error("input accepted in the middle of a sorted run");

endmodule

bind bitonic_sort_padded bsp_checker u_bsp_checker (.*);
